FILE: rtl/c25_pkg.sv
// ----------------------------------------------------------------------------
// c25_pkg
// Shared types and constants of the arithmetic unit for the field modulo
// 2^255 - 19.
// ----------------------------------------------------------------------------
package c25_pkg;

	localparam int LIMB_W  = 32;
	localparam int NCELL   = 8;
	localparam int FE_W    = LIMB_W * NCELL;
	localparam int PROD_W  = 2 * FE_W;
	localparam int STEP_W  = $clog2(2 * NCELL);
	localparam int BIT_W   = 8;
	localparam int IN_W    = 520;
	localparam int OUT_W   = 256;

	localparam logic [254:0] P_MOD =
		255'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffed;
	localparam logic [257:0] P_MOD_X4 =
		258'h1_ffffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffb4;
	localparam logic [254:0] EXP_PM2 =
		255'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffeb;
	localparam logic [FE_W-1:0] K_121666 = FE_W'(121666);
	localparam logic [BIT_W-1:0] EXP_TOP = BIT_W'(254);

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_SQR  = 3'd3,
		OP_MULK = 3'd4,
		OP_INV  = 3'd5
	} op_e_t;

	typedef struct packed {
		logic valid;
		logic internal;
	} c25_tag_t;

endpackage

FILE: rtl/c25_mul_cell.sv
// ----------------------------------------------------------------------------
// c25_mul_cell
// One cell of the multiplier row: a 32 by 32 bit multiply-accumulate that
// keeps a sum word and a carry word and hands its low word to its neighbour.
// ----------------------------------------------------------------------------
module c25_mul_cell (
	input  logic        clk,
	input  logic        en,
	input  logic        first,
	input  logic [31:0] a_word,
	input  logic [31:0] b_word,
	input  logic [31:0] lo_in,
	output logic [31:0] lo_out
);
	import c25_pkg::*;

	logic [LIMB_W-1:0]   lo_q;
	logic [LIMB_W-1:0]   hi_q;
	logic [2*LIMB_W-1:0] t;

	always_comb begin
		t = a_word * b_word;
		if (!first) begin
			t = t + {{LIMB_W{1'b0}}, lo_q} + {{LIMB_W{1'b0}}, hi_q};
		end
	end

	assign lo_out = t[LIMB_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			lo_q <= lo_in;
			hi_q <= t[2*LIMB_W-1:LIMB_W];
		end
	end

endmodule

FILE: rtl/c25_reduce.sv
// ----------------------------------------------------------------------------
// c25_reduce
// Four-stage pipeline that folds a value lo + 2^256 * hi and brings it to
// canonical form in [0, p).
// ----------------------------------------------------------------------------
module c25_reduce (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  c25_pkg::c25_tag_t       in_tag,
	input  logic [255:0]            in_lo,
	input  logic [255:0]            in_hi,
	output c25_pkg::c25_tag_t       out_tag,
	output logic [254:0]            out_r
);
	import c25_pkg::*;

	c25_tag_t     tag_s1, tag_s2, tag_s3, tag_s4;
	logic [262:0] v_s1;
	logic [255:0] x_s2;
	logic [254:0] y_s3;
	logic [254:0] r_s4;
	logic [255:0] t;

	assign t = {1'b0, y_s3} + 256'd19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (en) begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= {7'b0, in_lo} + ({7'b0, in_hi} << 5) + ({7'b0, in_hi} << 2)
				+ ({7'b0, in_hi} << 1);
			x_s2 <= {1'b0, v_s1[254:0]}
				+ {243'b0, 13'(v_s1[262:255]) * 13'd19};
			y_s3 <= x_s2[254:0] + (x_s2[255] ? 255'd19 : 255'd0);
			r_s4 <= t[255] ? t[254:0] : y_s3;
		end
	end

	assign out_tag = tag_s4;
	assign out_r   = r_s4;

`ifndef SYNTHESIS
	a_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s4.valid |-> r_s4 < P_MOD)
		else $error("reduced value not below the modulus");
	a_one_internal: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({in_tag.valid && in_tag.internal, tag_s1.valid && tag_s1.internal,
			tag_s2.valid && tag_s2.internal, tag_s3.valid && tag_s3.internal,
			tag_s4.valid && tag_s4.internal}) <= 1)
		else $error("more than one inversion step in flight");
`endif

endmodule

FILE: rtl/curve25519_field_alu.sv
// Each word carries an op code and two 256-bit operands and returns one word
// with the result fully reduced modulo 2^255 - 19. Add, subtract and the
// unused op codes follow each other every cycle unless the output stalls.
// Multiply, square and the multiply by 121666 run through a row of eight
// 32-bit multiply-accumulate cells, one 32-bit word of the second operand
// per cycle unless the output stalls, then drain the carries, and take no
// new word until the product has left the row. Inversion runs 255 squarings
// and 253 multiplications on the same row, each result fed back through the
// four-stage reduction pipeline. Results leave in arrival order, after the
// injection register and the four reduction stages.
// ----------------------------------------------------------------------------
// curve25519_field_alu
// Field arithmetic unit for p = 2^255 - 19 with stream ports.
// ----------------------------------------------------------------------------
module curve25519_field_alu (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// op, a0, a1, a2, a3, b0, b1, b2, b3, zero fill
	input  logic [c25_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// r0, r1, r2, r3, zero fill
	output logic [c25_pkg::OUT_W-1:0] m_tdata
);
	import c25_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DONE,
		ST_WAIT
	} state_t;

	state_t                      state_q;
	logic [STEP_W-1:0]           step_q;
	logic                        inv_q;
	logic                        sq_q;
	logic [BIT_W-1:0]            bit_q;
	c25_tag_t                    inj_tag_q;
	logic [FE_W-1:0]             inj_lo_q;
	logic [FE_W-1:0]             inj_hi_q;
	logic [NCELL-1:0][LIMB_W-1:0] mul_a_q;
	logic [NCELL-1:0][LIMB_W-1:0] mul_b_q;
	logic [PROD_W-1:0]           prod_q;
	logic [FE_W-1:0]             base_q;

	logic                        en;
	logic                        mul_go;
	logic [LIMB_W-1:0]           b_word;
	logic [NCELL:0][LIMB_W-1:0]  lo_link;
	op_e_t                       op;
	logic [FE_W-1:0]             a_in;
	logic [FE_W-1:0]             b_in;
	logic [FE_W:0]               sum;
	logic [257:0]                diff;
	c25_tag_t                    res_tag;
	logic [254:0]                res_r;
	logic                        res_int;
	logic                        next_is_mul;

	assign op   = op_e_t'(s_tdata[2:0]);
	assign a_in = s_tdata[3 +: FE_W];
	assign b_in = s_tdata[3 + FE_W +: FE_W];
	assign sum  = {1'b0, a_in} + {1'b0, b_in};
	assign diff = {2'b0, a_in} + (P_MOD_X4 - {2'b0, b_in});

	assign en       = !(res_tag.valid && !res_tag.internal && !m_tready);
	assign s_tready = (state_q == ST_IDLE) && en;
	assign mul_go   = (state_q == ST_MUL) && en;
	assign b_word   = step_q[STEP_W-1] ? '0 : mul_b_q[step_q[STEP_W-2:0]];
	assign res_int  = res_tag.valid && res_tag.internal;
	assign next_is_mul = sq_q && EXP_PM2[bit_q];

	assign lo_link[NCELL] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		c25_mul_cell u_cell (
			.clk    (clk),
			.en     (mul_go),
			.first  (step_q == '0),
			.a_word (mul_a_q[i]),
			.b_word (b_word),
			.lo_in  (lo_link[i+1]),
			.lo_out (lo_link[i])
		);
	end

	c25_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (inj_tag_q),
		.in_lo   (inj_lo_q),
		.in_hi   (inj_hi_q),
		.out_tag (res_tag),
		.out_r   (res_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			inv_q     <= 1'b0;
			sq_q      <= 1'b0;
			bit_q     <= '0;
			inj_tag_q <= '0;
		end else if (en) begin
			inj_tag_q <= '0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (op)
							OP_MUL, OP_SQR, OP_MULK: begin
								state_q <= ST_MUL;
								inv_q   <= 1'b0;
							end
							OP_INV: begin
								state_q <= ST_MUL;
								inv_q   <= 1'b1;
								sq_q    <= 1'b1;
								bit_q   <= EXP_TOP;
							end
							default: begin
								inj_tag_q <= '{valid: 1'b1, internal: 1'b0};
							end
						endcase
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == '1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					inj_tag_q <= '{valid: 1'b1, internal: inv_q};
					state_q   <= inv_q ? ST_WAIT : ST_IDLE;
				end
				ST_WAIT: begin
					if (res_int) begin
						if (next_is_mul) begin
							sq_q    <= 1'b0;
							state_q <= ST_MUL;
						end else if (bit_q == '0) begin
							inj_tag_q <= '{valid: 1'b1, internal: 1'b0};
							inv_q     <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							bit_q   <= bit_q - 1'b1;
							sq_q    <= 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						base_q <= a_in;
						case (op)
							OP_ADD: begin
								inj_lo_q <= sum[FE_W-1:0];
								inj_hi_q <= {{(FE_W-1){1'b0}}, sum[FE_W]};
							end
							OP_SUB: begin
								inj_lo_q <= diff[FE_W-1:0];
								inj_hi_q <= {{(FE_W-2){1'b0}}, diff[257:256]};
							end
							OP_MUL: begin
								mul_a_q <= a_in;
								mul_b_q <= b_in;
							end
							OP_SQR: begin
								mul_a_q <= a_in;
								mul_b_q <= a_in;
							end
							OP_MULK: begin
								mul_a_q <= a_in;
								mul_b_q <= K_121666;
							end
							OP_INV: begin
								mul_a_q <= FE_W'(1);
								mul_b_q <= FE_W'(1);
							end
							default: begin
								inj_lo_q <= '0;
								inj_hi_q <= '0;
							end
						endcase
					end
				end
				ST_MUL: begin
					prod_q <= {lo_link[0], prod_q[PROD_W-1:LIMB_W]};
				end
				ST_DONE: begin
					inj_lo_q <= prod_q[FE_W-1:0];
					inj_hi_q <= prod_q[PROD_W-1:FE_W];
				end
				ST_WAIT: begin
					if (res_int) begin
						mul_a_q  <= {1'b0, res_r};
						mul_b_q  <= next_is_mul ? base_q : {1'b0, res_r};
						inj_lo_q <= {1'b0, res_r};
						inj_hi_q <= '0;
					end
				end
				default: begin
					prod_q <= prod_q;
				end
			endcase
		end
	end

	assign m_tvalid = res_tag.valid && !res_tag.internal;
	assign m_tdata  = {1'b0, res_r};

`ifndef SYNTHESIS
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_MUL |-> step_q == '0)
		else $error("multiplier step count running outside a multiplication");
	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (op == OP_MUL || op == OP_SQR || op == OP_MULK
			|| op == OP_INV) |=> state_q == ST_MUL)
		else $error("multiplying word did not start the cell row");
	a_wait_inv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> inv_q)
		else $error("waiting for feedback outside an inversion");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the field arithmetic unit modulo 2^255 - 19.
// Words are sent with random gaps and results are taken with random stalls.
// Each result is checked against a prediction worked out in wide modular
// arithmetic for every op code, the unused ones included.
// ----------------------------------------------------------------------------
module tb_top;
	import c25_pkg::*;

	typedef logic [255:0] fe_t;

	typedef struct packed {
		logic [62:0] r3;
		logic [63:0] r2;
		logic [63:0] r1;
		logic [63:0] r0;
	} fe_result_t;

	localparam int  WATCHDOG_LIMIT = 60000;
	localparam fe_t PRIME          = {1'b0, P_MOD};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;

	fe_result_t expected_q[$];
	int         mismatches = 0;
	int         words_sent = 0;
	int         results_checked = 0;
	int         inversions_sent = 0;
	int         idle_cycles = 0;
	bit         no_idling = 1'b0;

	always #5 clk = ~clk;

	curve25519_field_alu dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	function automatic fe_t reduce_p(logic [511:0] x);
		return fe_t'(x % {256'd0, PRIME});
	endfunction

	function automatic fe_t field_mul(fe_t x, fe_t y);
		logic [511:0] prod;
		prod = {256'd0, reduce_p({256'd0, x})} * {256'd0, reduce_p({256'd0, y})};
		return reduce_p(prod);
	endfunction

	function automatic fe_t field_inv(fe_t x);
		fe_t acc;
		acc = 256'd1;
		for (int i = 254; i >= 0; i--) begin
			acc = field_mul(acc, acc);
			if (EXP_PM2[i])
				acc = field_mul(acc, x);
		end
		return acc;
	endfunction

	function automatic fe_result_t predict_field_op(logic [2:0] op, fe_t a, fe_t b);
		fe_t ar, br, r;
		ar = reduce_p({256'd0, a});
		br = reduce_p({256'd0, b});
		case (op)
			OP_ADD:  r = reduce_p({256'd0, ar} + {256'd0, br});
			OP_SUB:  r = reduce_p({256'd0, ar} + {256'd0, PRIME} - {256'd0, br});
			OP_MUL:  r = field_mul(ar, br);
			OP_SQR:  r = field_mul(ar, ar);
			OP_MULK: r = field_mul(ar, 256'd121666);
			OP_INV:  r = field_inv(ar);
			default: r = '0;
		endcase
		return fe_result_t'(r[254:0]);
	endfunction

	function automatic fe_t rand_fe();
		fe_t v;
		for (int i = 0; i < 8; i++)
			v[32*i +: 32] = $urandom;
		case ($urandom_range(0, 15))
			0: v = '0;
			1: v = PRIME - 256'd1;
			2: v = PRIME + fe_t'($urandom_range(0, 40));
			3: v = '1;
			4: v = fe_t'($urandom_range(0, 200));
			5: v = PRIME - fe_t'($urandom_range(1, 40));
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_word(logic [2:0] op, fe_t a, fe_t b);
		int  gap;
		logic rdy;
		gap = no_idling ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {5'd0, b[255:192], b[191:128], b[127:64], b[63:0],
			a[255:192], a[191:128], a[127:64], a[63:0], op};
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		expected_q.push_back(predict_field_op(op, a, b));
		words_sent++;
		if (op == OP_INV)
			inversions_sent++;
	endtask

	initial begin : result_checker
		int         stall;
		logic       got;
		fe_result_t actual, want;
		forever begin
			stall = no_idling ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				got    = m_tvalid && m_tready;
				actual = fe_result_t'(m_tdata[254:0]);
				@(posedge clk);
			end while (!got);
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word %h", actual);
			end else begin
				want = expected_q.pop_front();
				results_checked++;
				if (actual !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %h, actual %h", want, actual);
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_edge_operands();
		fe_t edges[5];
		edges[0] = '0;
		edges[1] = '1;
		edges[2] = PRIME;
		edges[3] = PRIME - 256'd1;
		edges[4] = PRIME + 256'd18;
		for (int i = 0; i < 5; i++) begin
			send_word(OP_ADD, edges[i], edges[4 - i]);
			send_word(OP_SUB, edges[i], edges[(i + 1) % 5]);
			send_word(OP_MUL, edges[i], edges[(i + 3) % 5]);
		end
		send_word(OP_SQR, '1, '0);
		send_word(OP_MULK, '1, '1);
	endtask

	task automatic test_each_op();
		send_word(OP_SQR, rand_fe(), rand_fe());
		send_word(OP_MULK, PRIME - 256'd1, '0);
		send_word(3'd6, rand_fe(), rand_fe());
		send_word(3'd7, '1, '1);
		send_word(OP_INV, '0, '1);
		send_word(OP_INV, PRIME, '0);
		send_word(OP_INV, rand_fe(), rand_fe());
	endtask

	task automatic test_random_words(int count);
		logic [2:0] op;
		int         pick;
		for (int n = 0; n < count; n++) begin
			no_idling = (n % 400) >= 300;
			pick = $urandom_range(0, 199);
			if (pick < 2)
				op = OP_INV;
			else if (pick < 8)
				op = 3'($urandom_range(6, 7));
			else
				op = 3'($urandom_range(0, 4));
			send_word(op, rand_fe(), rand_fe());
		end
		no_idling = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_operands();
		test_each_op();
		test_random_words(1600);
		s_tvalid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (50) @(posedge clk);
		$display("Sent %0d words (%0d inversions) and checked %0d results.",
			words_sent, inversions_sent, results_checked);
		$display("Mismatching results: %0d.", mismatches);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
